@@ src/rgbl_pkg.sv @@
// shared types, constants and helper functions for the rgb life cell updater
`default_nettype none
package rgbl_pkg;

  // field widths
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int SIZE_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int RULE_W    = 18;
  localparam int HALF_W    = 9;
  localparam int CNT_W     = 4;
  localparam int CELL_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd2;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // reset values and constants
  localparam logic [RULE_W-1:0] RULE_RESET = 18'h01808;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;
  localparam logic [BYTE_W-1:0] BYTE_ALIVE = 8'hFF;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // tag that travels with each grid read
  typedef struct packed {
    logic valid;
    logic centre;
    logic last;
  } tap_t;

  // size in use: zero reads as one, values above the cap saturate
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int cap);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (cap < (1 << SIZE_W) && int'(v) > cap) begin
      res = SIZE_W'(cap);
    end
    return res;
  endfunction

  // linear cell index in the grid store
  function automatic int cell_index(input logic [SIZE_W-1:0] r, input logic [SIZE_W-1:0] c,
                                    input int cols);
    return int'(r) * cols + int'(c);
  endfunction

  // next state from the survive or birth half of the rule
  function automatic logic next_alive(input logic [RULE_W-1:0] rule, input logic alive,
                                      input logic [CNT_W-1:0] cnt);
    logic [HALF_W-1:0] half;
    half = alive ? rule[RULE_W-1:HALF_W] : rule[HALF_W-1:0];
    return (cnt < CNT_W'(HALF_W)) ? half[cnt] : 1'b0;
  endfunction

endpackage
`default_nettype wire

@@ src/rgbl_cmd_if.sv @@
// request channel carrying load and evaluate items
`default_nettype none
interface rgbl_cmd_if;
  import rgbl_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [BYTE_W-1:0] red_in;
  logic [BYTE_W-1:0] green_in;
  logic [BYTE_W-1:0] blue_in;

  modport source(output valid, operation, row, column, red_in, green_in, blue_in,
                 input ready);
  modport sink(input valid, operation, row, column, red_in, green_in, blue_in,
               output ready);
endinterface
`default_nettype wire

@@ src/rgbl_res_if.sv @@
// result channel carrying next cell colours
`default_nettype none
interface rgbl_res_if;
  import rgbl_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;
  logic              out_of_range;

  modport source(output valid, red_out, green_out, blue_out, out_of_range, input ready);
  modport sink(input valid, red_out, green_out, blue_out, out_of_range, output ready);
endinterface
`default_nettype wire

@@ src/rgbl_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module rgbl_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                         wdata,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ src/rgbl_seq.sv @@
// walks the 3x3 window around a cell, one grid read per cycle
`default_nettype none
module rgbl_seq #(
  parameter int MAX_COLS = rgbl_pkg::DEF_MAX_COLS,
  parameter int AW       = 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [rgbl_pkg::ROW_W-1:0]  row,
  input  wire logic [rgbl_pkg::COL_W-1:0]  column,
  input  wire logic [rgbl_pkg::SIZE_W-1:0] rows,
  input  wire logic [rgbl_pkg::SIZE_W-1:0] cols,
  output logic                             busy,
  output logic [AW-1:0]                    addr,
  output rgbl_pkg::tap_t                   tap
);
  import rgbl_pkg::*;

  logic [1:0] dr;
  logic [1:0] dc;
  logic [SIZE_W-1:0] nr;
  logic [SIZE_W-1:0] nc;
  logic [SIZE_W-1:0] r_ext;
  logic [SIZE_W-1:0] c_ext;
  logic last_step;

  assign r_ext = SIZE_W'(row);
  assign c_ext = SIZE_W'(column);
  assign last_step = (dr == 2'd2) && (dc == 2'd2);

  // wrapped neighbour row and column
  always_comb begin
    case (dr)
      2'd0:    nr = (r_ext == '0) ? rows - SIZE_W'(1) : r_ext - SIZE_W'(1);
      2'd2:    nr = (r_ext + SIZE_W'(1) == rows) ? '0 : r_ext + SIZE_W'(1);
      default: nr = r_ext;
    endcase
    case (dc)
      2'd0:    nc = (c_ext == '0) ? cols - SIZE_W'(1) : c_ext - SIZE_W'(1);
      2'd2:    nc = (c_ext + SIZE_W'(1) == cols) ? '0 : c_ext + SIZE_W'(1);
      default: nc = c_ext;
    endcase
  end

  assign addr = AW'(cell_index(nr, nc, MAX_COLS));

  // window step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dr   <= 2'd0;
      dc   <= 2'd0;
    end else if (start) begin
      busy <= 1'b1;
      dr   <= 2'd0;
      dc   <= 2'd0;
    end else if (busy) begin
      if (last_step) begin
        busy <= 1'b0;
      end
      if (dc == 2'd2) begin
        dc <= 2'd0;
        dr <= dr + 2'd1;
      end else begin
        dc <= dc + 2'd1;
      end
    end
  end

  // tag lines up with the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tap <= '0;
    end else begin
      tap.valid  <= busy && !start;
      tap.centre <= (dr == 2'd1) && (dc == 2'd1);
      tap.last   <= last_step;
    end
  end
endmodule
`default_nettype wire

@@ src/rgbl_acc.sv @@
// per-channel neighbour counters and rule lookup
`default_nettype none
module rgbl_acc (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        clear,
  input  wire rgbl_pkg::tap_t              tap,
  input  wire logic [rgbl_pkg::CELL_W-1:0] rdata,
  input  wire logic [rgbl_pkg::RULE_W-1:0] rule,
  output logic                             done,
  output logic [rgbl_pkg::CELL_W-1:0]      next_bits
);
  import rgbl_pkg::*;

  logic [CNT_W-1:0]  cnt [CELL_W];
  logic [CELL_W-1:0] centre;

  // accumulate one neighbour per cycle, keep the centre aside
  always_ff @(posedge clk) begin
    if (clear) begin
      for (int ch = 0; ch < CELL_W; ch++) begin
        cnt[ch] <= '0;
      end
      centre <= '0;
    end else if (tap.valid) begin
      if (tap.centre) begin
        centre <= rdata;
      end else begin
        for (int ch = 0; ch < CELL_W; ch++) begin
          cnt[ch] <= cnt[ch] + CNT_W'(rdata[ch]);
        end
      end
    end
  end

  // done once the last tap is in
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tap.valid && tap.last && !clear;
    end
  end

  // rule lookup per channel
  always_comb begin
    for (int ch = 0; ch < CELL_W; ch++) begin
      next_bits[ch] = next_alive(rule, centre[ch], cnt[ch]);
    end
  end
endmodule
`default_nettype wire

@@ src/rgb_life_rule_cell_update.sv @@
// top level: rgb life cell updater with grid store and window sequencer
// load in range: stored, no result; out of range item: finish state to result register
// evaluate: window walk in the run state, then finish state loads the result register;
//   next request taken the cycle after; nine grid reads one per cycle on the single port
// result register frees the request side while a result waits to be taken
// reset clears control state and restores the registers; the grid is not cleared
`default_nettype none
module rgb_life_rule_cell_update #(
  parameter int MAX_ROWS = rgbl_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = rgbl_pkg::DEF_MAX_COLS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [rgbl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rgbl_pkg::CFG_DAT_W-1:0] cfg_data,
  rgbl_cmd_if.sink                            cmd,
  rgbl_res_if.source                          res
);
  import rgbl_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [RULE_W-1:0] rule_code;
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [SIZE_W-1:0] rows;
  logic [SIZE_W-1:0] cols;

  logic [1:0]        state;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  col_q;
  logic              oor_q;

  logic              accept;
  logic              in_range;
  logic              start;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_bits;
  logic [CELL_W-1:0] rd_bits;
  logic              seq_busy;
  logic [AW-1:0]     seq_addr;
  tap_t              tap;
  logic              acc_done;
  logic [CELL_W-1:0] next_bits;
  logic              out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_code <= RULE_RESET;
      grid_rows <= SIZE_RESET;
      grid_cols <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RULE: rule_code <= cfg_data[RULE_W-1:0];
        REG_ROWS: grid_rows <= cfg_data[SIZE_W-1:0];
        REG_COLS: grid_cols <= cfg_data[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  assign rows = eff_size(grid_rows, MAX_ROWS);
  assign cols = eff_size(grid_cols, MAX_COLS);

  // request decode
  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign in_range  = (SIZE_W'(cmd.row) < rows) && (SIZE_W'(cmd.column) < cols);
  assign start     = accept && in_range && (cmd.operation == OP_EVAL);
  assign ram_we    = accept && in_range && (cmd.operation == OP_LOAD);

  assign wr_bits = {cmd.blue_in == BYTE_ALIVE, cmd.green_in == BYTE_ALIVE,
                    cmd.red_in == BYTE_ALIVE};
  assign wr_addr = AW'(cell_index(SIZE_W'(cmd.row), SIZE_W'(cmd.column), MAX_COLS));
  assign ram_addr = ram_we ? wr_addr : seq_addr;

  rgbl_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wr_bits),
    .rdata(rd_bits)
  );

  rgbl_seq #(
    .MAX_COLS(MAX_COLS),
    .AW      (AW)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .row   (row_q),
    .column(col_q),
    .rows  (rows),
    .cols  (cols),
    .busy  (seq_busy),
    .addr  (seq_addr),
    .tap   (tap)
  );

  rgbl_acc u_acc (
    .clk      (clk),
    .rst      (rst),
    .clear    (start),
    .tap      (tap),
    .rdata    (rd_bits),
    .rule     (rule_code),
    .done     (acc_done),
    .next_bits(next_bits)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q <= cmd.row;
      col_q <= cmd.column;
      oor_q <= !in_range;
    end
  end

  // sequencer control
  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end else if (accept && !in_range) begin
            state <= ST_FIN;
          end
        end
        ST_RUN: begin
          if (acc_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      res.red_out      <= oor_q ? '0 : {BYTE_W{next_bits[0]}};
      res.green_out    <= oor_q ? '0 : {BYTE_W{next_bits[1]}};
      res.blue_out     <= oor_q ? '0 : {BYTE_W{next_bits[2]}};
      res.out_of_range <= oor_q;
    end
  end

  // the window walk only runs while an evaluate is in flight
  a_busy_in_run: assert property (@(posedge clk) disable iff (rst)
    seq_busy |-> state == ST_RUN)
    else $error("window sequencer busy outside run state");

  // a load never collides with a window read
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !seq_busy && !tap.valid)
    else $error("grid write during window walk");

  // counts complete only while evaluating
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    acc_done |-> state == ST_RUN)
    else $error("counter done outside run state");

  // a new result only comes from the finish state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ST_FIN))
    else $error("result raised outside finish state");

endmodule
`default_nettype wire
